[hdl/string_literal_unescaper_unit_macros.svh]
// Assertion macros of the string literal unescaper checker.
// Depends on signals named clk and arst_n in the scope of each use.
`ifndef STRING_LITERAL_UNESCAPER_UNIT_MACROS_SVH
`define STRING_LITERAL_UNESCAPER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SLU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("slu check failed");

// Consequent must hold in the cycle after the antecedent
`define SLU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("slu check failed");

`endif

[hdl/slu_pkg.sv]
// Shared types, codes and decode helpers of the string literal unescaper.
// No dependencies; used by the result queue, the top level and the checker.
`default_nettype none

package slu_pkg;

	// Escape decoder mode
	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESCAPE,
		MODE_OCTAL,
		MODE_HEX
	} esc_mode_t;

	// Error codes carried with each result word
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_HEX  = 2'd1;
	localparam logic [1:0] ERR_DANGLING = 2'd2;
	localparam logic [1:0] ERR_NO_QUOTE = 2'd3;

	// Characters of interest
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;
	localparam logic [7:0] CH_LOWER_B   = 8'h62;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_V   = 8'h76;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_7   = 8'h37;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;

	// Control characters produced by the simple escapes
	localparam logic [7:0] CTL_BS  = 8'd8;
	localparam logic [7:0] CTL_FF  = 8'd12;
	localparam logic [7:0] CTL_LF  = 8'd10;
	localparam logic [7:0] CTL_CR  = 8'd13;
	localparam logic [7:0] CTL_TAB = 8'd9;
	localparam logic [7:0] CTL_BEL = 8'd7;
	localparam logic [7:0] CTL_VT  = 8'd11;

	// Result queue sizing: one input byte yields at most three results
	localparam int RES_MAX    = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// One result word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic [1:0] error_code;
	} result_t;

	// Queue status seen by the decoder
	typedef struct packed {
		logic room;
		logic not_empty;
	} fifo_status_t;

	// Decode event: push a decoded byte or report an error
	typedef enum logic [1:0] {
		EV_NONE,
		EV_PUSH,
		EV_ERROR
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] value;
		logic [1:0] err;
	} event_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic event_t ev_push(input logic [7:0] b);
		event_t e;
		e.kind  = EV_PUSH;
		e.value = b;
		e.err   = ERR_NONE;
		return e;
	endfunction

	function automatic event_t ev_error(input logic [1:0] code);
		event_t e;
		e.kind  = EV_ERROR;
		e.value = 8'd0;
		e.err   = code;
		return e;
	endfunction

	function automatic event_t ev_idle();
		event_t e;
		e.kind  = EV_NONE;
		e.value = 8'd0;
		e.err   = ERR_NONE;
		return e;
	endfunction

	// Map the byte after a backslash to its control character
	function automatic logic [7:0] simple_escape(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CH_LOWER_B: r = CTL_BS;
			CH_LOWER_F: r = CTL_FF;
			CH_LOWER_N: r = CTL_LF;
			CH_LOWER_R: r = CTL_CR;
			CH_LOWER_T: r = CTL_TAB;
			CH_LOWER_A: r = CTL_BEL;
			CH_LOWER_V: r = CTL_VT;
			default:    r = c;
		endcase
		return r;
	endfunction

	// Value of a hex digit of either case
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			h.value = c[3:0];
		end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
				(c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
			h.value = c[3:0] + 4'd9;
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

[hdl/slu_if.sv]
// Valid/ready channel interfaces of the string literal unescaper.
// Depends on nothing but the language; one interface per direction of word.
`default_nettype none

// Raw literal bytes
interface slu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_literal;

	modport source (output valid, output in_byte, output end_of_literal, input ready);
	modport sink (input valid, input in_byte, input end_of_literal, output ready);
endinterface

// Decoded result words
interface slu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       string_end;
	logic [1:0] error_code;

	modport source (output valid, output out_byte, output byte_valid, output string_end,
		output error_code, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input string_end,
		input error_code, output ready);
endinterface

`default_nettype wire

[hdl/string_literal_unescaper_unit.sv]
// String literal unescaper: takes one raw byte of a quoted literal per cycle and
// decodes C escapes (simple, octal of up to three digits, hex of up to two digits),
// dropping the opening quote and the closing decoded byte. Each accepted byte is
// decoded in the same cycle against the escape state and written, as zero to three
// result words, into a four-entry result queue that drains one word per cycle while
// the output is ready. The input is ready whenever the queue holds at most one word,
// so a stream sustains one byte per cycle while the output keeps up; the end of a
// literal yields up to three words, and the next byte waits until the queue has
// drained to one word. There is no clearing pass: the input is held not ready until
// a run register, cleared by reset, is set after reset is released.
// Depends on slu_pkg, slu_if and slu_result_fifo.
`default_nettype none

module string_literal_unescaper_unit (
	input  wire       clk,
	input  wire       arst_n,
	slu_in_if.sink    literal,
	slu_out_if.source decoded
);
	import slu_pkg::*;

	// Escape state
	esc_mode_t  mode_q, mode_d, mode_nx;
	logic [1:0] cnt_q, cnt_d, cnt_nx;
	logic [8:0] acc_q, acc_d, acc_nx;
	logic [7:0] held_q, held_nx;
	logic       held_v_q, held_v_nx;
	logic       first_q, first_nx;
	logic       run_q;

	logic       accept;
	logic [7:0] c;
	logic       last;
	logic       is_oct;
	logic       as_plain;
	hex_t       hx;
	event_t     ev [RES_MAX];

	logic       h_v;
	logic [7:0] h_b;
	logic [1:0] n;
	result_t [RES_MAX-1:0] res;
	fifo_status_t status;
	result_t    rd_data;

	assign c      = literal.in_byte;
	assign last   = literal.end_of_literal;
	assign accept = literal.valid && literal.ready;
	assign literal.ready = run_q && status.room;

	// Turn the byte into decode events: run close, main decode, end flush
	always_comb begin
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		as_plain = 1'b0;
		hx       = hex_digit(c);
		is_oct   = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_7);
		for (int i = 0; i < RES_MAX; i++) begin
			ev[i] = ev_idle();
		end
		if (!first_q) begin
			case (mode_q)
				MODE_OCTAL: begin
					if (is_oct) begin
						acc_d = {acc_q[5:0], c[2:0]};
						cnt_d = cnt_q + 2'd1;
						if (cnt_d == 2'd3) begin
							ev[1]  = ev_push(acc_d[7:0]);
							mode_d = MODE_NORMAL;
						end
					end else begin
						ev[0]    = ev_push(acc_q[7:0]);
						mode_d   = MODE_NORMAL;
						as_plain = 1'b1;
					end
				end
				MODE_HEX: begin
					if (hx.valid) begin
						acc_d = {acc_q[4:0], hx.value};
						cnt_d = cnt_q + 2'd1;
						if (cnt_d == 2'd2) begin
							ev[1]  = ev_push(acc_d[7:0]);
							mode_d = MODE_NORMAL;
						end
					end else begin
						ev[0]    = (cnt_q == 2'd0) ? ev_error(ERR_BAD_HEX) :
							ev_push(acc_q[7:0]);
						mode_d   = MODE_NORMAL;
						as_plain = 1'b1;
					end
				end
				MODE_ESCAPE: begin
					if (is_oct) begin
						mode_d = MODE_OCTAL;
						acc_d  = {6'd0, c[2:0]};
						cnt_d  = 2'd1;
					end else if (c == CH_LOWER_X) begin
						mode_d = MODE_HEX;
						acc_d  = '0;
						cnt_d  = 2'd0;
					end else begin
						ev[1]  = ev_push(simple_escape(c));
						mode_d = MODE_NORMAL;
					end
				end
				default: begin
					as_plain = 1'b1;
				end
			endcase
		end
		// Ordinary byte after a closed run or in normal mode
		if (as_plain) begin
			if (c == CH_BACKSLASH) begin
				mode_d = MODE_ESCAPE;
			end else begin
				ev[1] = ev_push(c);
			end
		end
		// Flush an open escape at the end of the literal
		if (last) begin
			case (mode_d)
				MODE_ESCAPE: ev[2] = ev_error(ERR_DANGLING);
				MODE_OCTAL:  ev[2] = ev_push(acc_d[7:0]);
				MODE_HEX:    ev[2] = (cnt_d == 2'd0) ? ev_error(ERR_BAD_HEX) :
					ev_push(acc_d[7:0]);
				default:     ev[2] = ev_idle();
			endcase
		end
	end

	// Resolve events against the held byte into result words
	always_comb begin
		h_v = held_v_q;
		h_b = held_q;
		n   = 2'd0;
		res = '0;
		for (int i = 0; i < RES_MAX; i++) begin
			case (ev[i].kind)
				EV_PUSH: begin
					if (h_v) begin
						res[n] = '{out_byte: h_b, byte_valid: 1'b1, string_end: 1'b0,
							error_code: ERR_NONE};
						n = n + 2'd1;
					end
					h_b = ev[i].value;
					h_v = 1'b1;
				end
				EV_ERROR: begin
					res[n] = '{out_byte: 8'd0, byte_valid: 1'b0, string_end: 1'b0,
						error_code: ev[i].err};
					n = n + 2'd1;
				end
				default: begin
				end
			endcase
		end
		// Closing word drops the held byte and checks it for the quote
		if (last) begin
			res[n] = '{out_byte: 8'd0, byte_valid: 1'b0, string_end: 1'b1,
				error_code: (h_v && h_b == CH_QUOTE) ? ERR_NONE : ERR_NO_QUOTE};
			n = n + 2'd1;
		end
		if (last) begin
			mode_nx   = MODE_NORMAL;
			cnt_nx    = 2'd0;
			acc_nx    = '0;
			held_nx   = 8'd0;
			held_v_nx = 1'b0;
			first_nx  = 1'b1;
		end else begin
			mode_nx   = mode_d;
			cnt_nx    = cnt_d;
			acc_nx    = acc_d;
			held_nx   = h_b;
			held_v_nx = h_v;
			first_nx  = 1'b0;
		end
	end

	// Hold escape state, advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			cnt_q    <= 2'd0;
			acc_q    <= '0;
			held_q   <= 8'd0;
			held_v_q <= 1'b0;
			first_q  <= 1'b1;
			run_q    <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (accept) begin
				mode_q   <= mode_nx;
				cnt_q    <= cnt_nx;
				acc_q    <= acc_nx;
				held_q   <= held_nx;
				held_v_q <= held_v_nx;
				first_q  <= first_nx;
			end
		end
	end

	slu_result_fifo u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_num   (accept ? n : 2'd0),
		.wr_data  (res),
		.status   (status),
		.rd_ready (decoded.ready),
		.rd_data  (rd_data)
	);

	assign decoded.valid      = status.not_empty;
	assign decoded.out_byte   = rd_data.out_byte;
	assign decoded.byte_valid = rd_data.byte_valid;
	assign decoded.string_end = rd_data.string_end;
	assign decoded.error_code = rd_data.error_code;

endmodule

`default_nettype wire

[hdl/slu_result_fifo.sv]
// Four-entry result queue: takes up to three result words per cycle, gives one.
// Depends on slu_pkg.
`default_nettype none

module slu_result_fifo (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire  [1:0]                                wr_num,
	input  slu_pkg::result_t [slu_pkg::RES_MAX-1:0]   wr_data,
	output slu_pkg::fifo_status_t                     status,
	input  wire                                       rd_ready,
	output slu_pkg::result_t                          rd_data
);
	import slu_pkg::*;

	result_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic [FIFO_AW-1:0] slot_off [FIFO_DEPTH];
	logic               pop;

	// Offset of each entry from the write pointer
	always_comb begin
		for (int j = 0; j < FIFO_DEPTH; j++) begin
			slot_off[j] = FIFO_AW'(j) - wr_ptr_q;
		end
	end

	assign pop              = status.not_empty && rd_ready;
	assign status.not_empty = (count_q != '0);
	assign status.room      = (count_q <= (FIFO_AW+1)'(FIFO_DEPTH - RES_MAX));
	assign rd_data          = mem_q[rd_ptr_q];

	// Write the new words at consecutive entries
	always_ff @(posedge clk) begin
		for (int j = 0; j < FIFO_DEPTH; j++) begin
			if (slot_off[j] < wr_num) begin
				mem_q[j] <= wr_data[slot_off[j]];
			end
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + wr_num;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {1'b0, wr_num} - {{FIFO_AW{1'b0}}, pop};
		end
	end

endmodule

`default_nettype wire

[hdl/slu_checker.sv]
// Port-level checker for the string literal unescaper, bound to the top level.
// Depends on slu_pkg and string_literal_unescaper_unit_macros.svh.
`default_nettype none
`include "string_literal_unescaper_unit_macros.svh"

module slu_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       in_end,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_byte,
	input wire       byte_valid,
	input wire       string_end,
	input wire [1:0] error_code
);
	import slu_pkg::*;

	// A stalled result word holds
	`SLU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_byte, byte_valid, string_end, error_code}))

	// A decoded byte carries no error and no end mark
	`SLU_ASSERT_SAME(a_byte_clean, out_valid && byte_valid, !string_end && error_code == ERR_NONE)

	// A word without a byte carries a zero byte
	`SLU_ASSERT_SAME(a_empty_zero, out_valid && !byte_valid, out_byte == 8'd0)

	// The end of a literal always leaves a closing word to deliver
	`SLU_ASSERT_NEXT(a_end_result, in_valid && in_ready && in_end, out_valid)

endmodule

bind string_literal_unescaper_unit slu_checker u_slu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (literal.valid),
	.in_ready   (literal.ready),
	.in_end     (literal.end_of_literal),
	.out_valid  (decoded.valid),
	.out_ready  (decoded.ready),
	.out_byte   (decoded.out_byte),
	.byte_valid (decoded.byte_valid),
	.string_end (decoded.string_end),
	.error_code (decoded.error_code)
);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for string_literal_unescaper_unit: drives quoted literals byte by byte
// and checks every decoded word against an in-bench decoder. Depends on slu_pkg and slu_if.
module tb_top;
	import slu_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int IDLE_PCT     = 16;
	localparam int HOLD_CYCLES  = 60;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	localparam logic [7:0] SIMPLE_LETTERS [7] = '{CH_LOWER_B, CH_LOWER_F, CH_LOWER_N,
		CH_LOWER_R, CH_LOWER_T, CH_LOWER_A, CH_LOWER_V};

	logic clk = 1'b0;
	logic arst_n;

	slu_in_if  literal_ch ();
	slu_out_if decoded_ch ();

	string_literal_unescaper_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.literal (literal_ch),
		.decoded (decoded_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decoder state mirrored in the bench
	esc_mode_t  dec_mode;
	logic [1:0] dig_cnt;
	logic [8:0] esc_acc;
	logic [7:0] held_b;
	logic       held_v;
	logic       opening_due;
	result_t    words_due[$];

	int  fail_count = 0;
	int  words_sent = 0;
	int  stall_cycles = 0;
	bit  calm = 1'b0;
	int  hold_req = 0;
	int  hold_ack = 0;
	int  hold_left = 0;

	function void clear_decoder();
		dec_mode    = MODE_NORMAL;
		dig_cnt     = 2'd0;
		esc_acc     = 9'd0;
		held_b      = 8'd0;
		held_v      = 1'b0;
		opening_due = 1'b1;
	endfunction

	function void add_word(input logic [7:0] b, input logic bv, input logic se,
			input logic [1:0] err);
		result_t w;
		w.out_byte   = b;
		w.byte_valid = bv;
		w.string_end = se;
		w.error_code = err;
		words_due.push_back(w);
	endfunction

	// Release the held byte as a word and hold the new one back
	function void hold_byte(input logic [7:0] b);
		if (held_v)
			add_word(held_b, 1'b1, 1'b0, ERR_NONE);
		held_b = b;
		held_v = 1'b1;
	endfunction

	function automatic logic is_octal(input logic [7:0] c);
		return c >= CH_DIGIT_0 && c <= CH_DIGIT_7;
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
			return int'(c - CH_DIGIT_0);
		if (c >= CH_LOWER_A && c <= CH_LOWER_F)
			return int'(c - CH_LOWER_A) + 10;
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	function automatic logic [7:0] control_for(input logic [7:0] c);
		case (c)
			CH_LOWER_B: return CTL_BS;
			CH_LOWER_F: return CTL_FF;
			CH_LOWER_N: return CTL_LF;
			CH_LOWER_R: return CTL_CR;
			CH_LOWER_T: return CTL_TAB;
			CH_LOWER_A: return CTL_BEL;
			CH_LOWER_V: return CTL_VT;
			default:    return c;
		endcase
	endfunction

	// Decode one byte after the opening quote
	function void decode_char(input logic [7:0] c);
		int  nib;
		bit  plain;
		plain = 1'b0;
		nib = hex_nibble(c);
		case (dec_mode)
			MODE_OCTAL: begin
				if (is_octal(c)) begin
					esc_acc = {esc_acc[5:0], c[2:0]};
					dig_cnt = dig_cnt + 2'd1;
					if (dig_cnt == 2'd3) begin
						hold_byte(esc_acc[7:0]);
						dec_mode = MODE_NORMAL;
					end
				end else begin
					hold_byte(esc_acc[7:0]);
					dec_mode = MODE_NORMAL;
					plain = 1'b1;
				end
			end
			MODE_HEX: begin
				if (nib >= 0) begin
					esc_acc = {esc_acc[4:0], 4'(nib)};
					dig_cnt = dig_cnt + 2'd1;
					if (dig_cnt == 2'd2) begin
						hold_byte(esc_acc[7:0]);
						dec_mode = MODE_NORMAL;
					end
				end else begin
					if (dig_cnt == 2'd0)
						add_word(8'd0, 1'b0, 1'b0, ERR_BAD_HEX);
					else
						hold_byte(esc_acc[7:0]);
					dec_mode = MODE_NORMAL;
					plain = 1'b1;
				end
			end
			MODE_ESCAPE: begin
				if (is_octal(c)) begin
					dec_mode = MODE_OCTAL;
					esc_acc  = {6'd0, c[2:0]};
					dig_cnt  = 2'd1;
				end else if (c == CH_LOWER_X) begin
					dec_mode = MODE_HEX;
					esc_acc  = 9'd0;
					dig_cnt  = 2'd0;
				end else begin
					hold_byte(control_for(c));
					dec_mode = MODE_NORMAL;
				end
			end
			default: plain = 1'b1;
		endcase
		if (plain) begin
			if (c == CH_BACKSLASH)
				dec_mode = MODE_ESCAPE;
			else
				hold_byte(c);
		end
	endfunction

	// Work out the words caused by one accepted input word
	function void predict_word(input logic [7:0] c, input logic last);
		if (opening_due)
			opening_due = 1'b0;
		else
			decode_char(c);
		if (last) begin
			case (dec_mode)
				MODE_ESCAPE: add_word(8'd0, 1'b0, 1'b0, ERR_DANGLING);
				MODE_OCTAL:  hold_byte(esc_acc[7:0]);
				MODE_HEX: begin
					if (dig_cnt == 2'd0)
						add_word(8'd0, 1'b0, 1'b0, ERR_BAD_HEX);
					else
						hold_byte(esc_acc[7:0]);
				end
				default: ;
			endcase
			add_word(8'd0, 1'b0, 1'b1,
				(held_v && held_b == CH_QUOTE) ? ERR_NONE : ERR_NO_QUOTE);
			clear_decoder();
		end
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Offer one word, idling first at random, and wait for the handshake
	task automatic send_word(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			literal_ch.valid <= 1'b0;
			@(posedge clk);
		end
		literal_ch.valid          <= 1'b1;
		literal_ch.in_byte        <= b;
		literal_ch.end_of_literal <= last;
		do @(posedge clk); while (!literal_ch.ready);
		predict_word(b, last);
		words_sent++;
	endtask

	task automatic send_literal(input byte_q_t q);
		foreach (q[i])
			send_word(q[i], i == q.size() - 1);
	endtask

	// Drop valid and hold until every predicted word has come out
	task automatic wait_drained();
		literal_ch.valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic byte_q_t text_bytes(input string s);
		byte_q_t q;
		q = {};
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'(CH_DIGIT_0 + v);
		return 8'(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + v - 10);
	endfunction

	// Build a literal: mostly well formed escapes, some raw noise and broken endings
	function automatic byte_q_t random_literal();
		byte_q_t    q;
		int         n_tok;
		logic [7:0] c;
		q = {};
		if ($urandom_range(9) == 0)
			q.push_back(8'($urandom_range(255)));
		else
			q.push_back(CH_QUOTE);
		n_tok = $urandom_range(6);
		repeat (n_tok) begin
			case ($urandom_range(9))
				0, 1: begin
					c = 8'($urandom_range(8'h20, 8'h7E));
					q.push_back(c == CH_BACKSLASH ? CH_UPPER_A : c);
				end
				2: q.push_back(8'($urandom_range(255)));
				3: begin
					q.push_back(CH_BACKSLASH);
					q.push_back(SIMPLE_LETTERS[$urandom_range(6)]);
				end
				4: begin
					q.push_back(CH_BACKSLASH);
					repeat ($urandom_range(1, 3))
						q.push_back(8'(CH_DIGIT_0 + $urandom_range(7)));
				end
				5: begin
					q.push_back(CH_BACKSLASH);
					q.push_back(CH_LOWER_X);
					repeat ($urandom_range(2))
						q.push_back(random_hex_char());
				end
				6: begin
					q.push_back(CH_BACKSLASH);
					q.push_back(8'($urandom_range(255)));
				end
				7: q.push_back(CH_QUOTE);
				8: begin
					q.push_back(CH_BACKSLASH);
					q.push_back($urandom_range(1) ? CH_BACKSLASH : CH_QUOTE);
				end
				default: begin
					q.push_back(CH_BACKSLASH);
					q.push_back(8'(CH_DIGIT_0 + $urandom_range(1)));
					q.push_back(8'(CH_DIGIT_0 + $urandom_range(8, 9)));
				end
			endcase
		end
		case ($urandom_range(9))
			7: q.push_back(CH_BACKSLASH);
			8: begin
				q.push_back(CH_BACKSLASH);
				q.push_back(8'(CH_DIGIT_0 + $urandom_range(7)));
			end
			9: ;
			default: q.push_back(CH_QUOTE);
		endcase
		return q;
	endfunction

	task automatic send_random_words(input int count);
		int target;
		target = words_sent + count;
		while (words_sent < target)
			send_literal(random_literal());
	endtask

	// Extremes of the byte, each escape kind, and the error endings
	task automatic test_directed();
		byte_q_t q;
		q = {8'hFF};
		send_literal(q);
		send_literal(text_bytes("\"\\ta\\101\\xG\""));
		send_literal(text_bytes("\"\\18\""));
		send_literal(text_bytes("\"\\x4"));
		q = {CH_QUOTE, 8'h00, CH_BACKSLASH};
		send_literal(q);
		wait_drained();
	endtask

	task automatic test_random_idle();
		calm <= 1'b0;
		send_random_words(300);
		wait_drained();
	endtask

	task automatic test_no_idle();
		calm <= 1'b1;
		send_random_words(100);
		calm <= 1'b0;
		wait_drained();
	endtask

	// Stall the output for a long stretch while input keeps coming
	task automatic test_backpressure();
		calm     <= 1'b1;
		hold_req <= hold_req + 1;
		send_random_words(100);
		calm <= 1'b0;
		wait_drained();
	endtask

	// Output side: random stalls, calm stretches and requested hold-offs
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			decoded_ch.ready <= 1'b0;
		end else if (calm) begin
			decoded_ch.ready <= 1'b1;
		end else begin
			decoded_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each accepted word with the oldest prediction
	always @(posedge clk) begin : check_words
		result_t got;
		result_t want;
		if (arst_n && decoded_ch.valid && decoded_ch.ready) begin
			got.out_byte   = decoded_ch.out_byte;
			got.byte_valid = decoded_ch.byte_valid;
			got.string_end = decoded_ch.string_end;
			got.error_code = decoded_ch.error_code;
			if (words_due.size() == 0) begin
				note_failure($sformatf("unexpected word byte=%02h bv=%0d end=%0d err=%0d",
					got.out_byte, got.byte_valid, got.string_end, got.error_code));
			end else begin
				want = words_due.pop_front();
				if (got !== want)
					note_failure($sformatf(
						"mismatch exp byte=%02h bv=%0d end=%0d err=%0d got byte=%02h bv=%0d end=%0d err=%0d",
						want.out_byte, want.byte_valid, want.string_end, want.error_code,
						got.out_byte, got.byte_valid, got.string_end, got.error_code));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (literal_ch.valid && literal_ch.ready) ||
				(decoded_ch.valid && decoded_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[string_literal_unescaper_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n                    = 1'b0;
		literal_ch.valid          = 1'b0;
		literal_ch.in_byte        = 8'd0;
		literal_ch.end_of_literal = 1'b0;
		decoded_ch.ready          = 1'b0;
		clear_decoder();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_idle();
		test_no_idle();
		test_backpressure();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[string_literal_unescaper_unit] OK");
		else
			$display("[string_literal_unescaper_unit] ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/slu_pkg.sv
hdl/slu_if.sv
hdl/slu_result_fifo.sv
hdl/string_literal_unescaper_unit.sv
hdl/slu_checker.sv
sim/tb_top.sv
